/* rtl/dtip_pkg.sv */
package dtip_pkg;

  localparam logic [30:0] MOD_PRIME = 31'h7fff_ffff;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_POINT = 8'd46;
  localparam logic [7:0] CH_ZERO = 8'd48;
  localparam logic [7:0] CH_NINE = 8'd57;

  localparam logic [1:0] PH_LEAD = 2'd0;
  localparam logic [1:0] PH_INT = 2'd1;
  localparam logic [1:0] PH_FRAC = 2'd2;

  typedef struct packed {
    logic [7:0] char_code;
    logic       has_char;
    logic       last;
  } item_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic               valid_res;
  } result_t;

endpackage

/* rtl/dtip_if.sv */
interface dtip_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       has_char;
  logic       last;

  modport source (output valid, output char_code, output has_char, output last, input ready);
  modport sink (input valid, input char_code, input has_char, input last, output ready);
endinterface

interface dtip_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic               valid_res;

  modport source (output valid, output value, output valid_res, input ready);
  modport sink (input valid, input value, input valid_res, output ready);
endinterface

/* rtl/dtip_in_reg.sv */
module dtip_in_reg import dtip_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  item_t in_item,
  output logic  in_ready,
  input  logic  go,
  output logic  s1_valid,
  output item_t s1_item
);

  // stage may refill whenever it is empty or moving on
  assign in_ready = go || !s1_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_item <= in_item;
    end
  end

endmodule

/* rtl/dtip_core.sv */
module dtip_core import dtip_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    s1_valid,
  input  item_t   s1_item,
  output logic    go,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  logic [1:0]  phase, phase_next;
  logic        negative, negative_next;
  logic [30:0] acc, acc_next;
  logic        bad_line, bad_line_next;

  logic        is_digit;
  logic [7:0]  diff;
  logic [34:0] prod;
  logic [31:0] fold;
  logic [30:0] acc_add;
  logic        take;
  result_t     res_next;

  assign go = !(out_valid && !out_ready);
  assign take = s1_valid && go;

  // acc*10 + digit, then fold 2^31 back as 1 (mersenne)
  always_comb begin
    diff = s1_item.char_code - CH_ZERO;
    is_digit = s1_item.char_code inside {[CH_ZERO:CH_NINE]};
    prod = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {31'b0, diff[3:0]};
    fold = {28'b0, prod[34:31]} + {1'b0, prod[30:0]};
    if (fold >= {1'b0, MOD_PRIME}) begin
      fold = fold - {1'b0, MOD_PRIME};
    end
    acc_add = fold[30:0];
  end

  always_comb begin
    phase_next = phase;
    negative_next = negative;
    acc_next = acc;
    bad_line_next = bad_line;
    if (s1_item.has_char && !bad_line) begin
      case (phase)
        PH_LEAD: begin
          if (s1_item.char_code == CH_SPACE) begin
            phase_next = PH_LEAD;
          end else if (s1_item.char_code == CH_MINUS) begin
            negative_next = 1'b1;
            phase_next = PH_INT;
          end else if (is_digit) begin
            acc_next = acc_add;
            phase_next = PH_INT;
          end else if (s1_item.char_code == CH_POINT) begin
            phase_next = PH_FRAC;
          end else begin
            bad_line_next = 1'b1;
          end
        end
        PH_INT: begin
          if (is_digit) begin
            acc_next = acc_add;
          end else if (s1_item.char_code == CH_POINT) begin
            phase_next = PH_FRAC;
          end else begin
            bad_line_next = 1'b1;
          end
        end
        default: begin
          if (s1_item.char_code != CH_ZERO) begin
            bad_line_next = 1'b1;
          end
        end
      endcase
    end
    if (bad_line_next) begin
      res_next.value = '0;
      res_next.valid_res = 1'b0;
    end else begin
      res_next.value = negative_next ? -$signed({1'b0, acc_next}) : $signed({1'b0, acc_next});
      res_next.valid_res = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_LEAD;
      negative <= 1'b0;
      acc <= '0;
      bad_line <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (go) begin
        out_valid <= s1_valid && s1_item.last;
      end
      if (take) begin
        if (s1_item.last) begin
          phase <= PH_LEAD;
          negative <= 1'b0;
          acc <= '0;
          bad_line <= 1'b0;
        end else begin
          phase <= phase_next;
          negative <= negative_next;
          acc <= acc_next;
          bad_line <= bad_line_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && s1_item.last) begin
      out_res <= res_next;
    end
  end

endmodule

/* rtl/decimal_text_to_integer_parser.sv */
// channel   dir  payload                           transaction
// chars     in   char_code[7:0] has_char last      one character
// results   out  value[31:0] signed, valid_res     one line result
//
// one character per cycle while results are not stalled; the result is valid once the last
// character has passed the input register and the state/result register
// the multiply-by-ten with mersenne fold is combinational logic for each character
// rst is synchronous, active high, and clears the line state
// a waiting result holds both stages; the input stage still fills if empty
module decimal_text_to_integer_parser import dtip_pkg::*; (
  input logic             clk,
  input logic             rst,
  dtip_char_if.sink       chars,
  dtip_result_if.source   results
);

  item_t   in_item;
  item_t   s1_item;
  logic    s1_valid;
  logic    go;
  result_t out_res;

  assign in_item.char_code = chars.char_code;
  assign in_item.has_char = chars.has_char;
  assign in_item.last = chars.last;

  dtip_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (chars.valid),
    .in_item  (in_item),
    .in_ready (chars.ready),
    .go       (go),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  dtip_core u_core (
    .clk       (clk),
    .rst       (rst),
    .s1_valid  (s1_valid),
    .s1_item   (s1_item),
    .go        (go),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .out_res   (out_res)
  );

  assign results.value = out_res.value;
  assign results.valid_res = out_res.valid_res;

endmodule

/* rtl/dtip_checker.sv */
module dtip_props (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] value,
  input logic               valid_res
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(value) && $stable(valid_res))
    else $error("result changed while stalled");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !valid_res |-> value == 32'sd0)
    else $error("invalid line with nonzero value");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> value != 32'sh7fff_ffff && value != 32'sh8000_0000 &&
      value != 32'sh8000_0001)
    else $error("value outside reduced range");

endmodule

bind decimal_text_to_integer_parser dtip_props u_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (results.valid),
  .out_ready (results.ready),
  .value     (results.value),
  .valid_res (results.valid_res)
);
